>>> hdl/lcube_pkg.sv
// ----------------------------------------------------------------------------
// LED cube driver package
// Cube geometry, store layout, the command word between the front and back
// parts, and a helper function.
// ----------------------------------------------------------------------------
package lcube_pkg;

  localparam int CUBE_SIDE   = 8;
  localparam int FRAME_BYTES = CUBE_SIDE * CUBE_SIDE;
  localparam int STORE_BYTES = 2 * FRAME_BYTES;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int SIDE_W      = $clog2(CUBE_SIDE);
  localparam int COUNT_W     = $clog2(FRAME_BYTES);
  localparam int BYTE_W      = 8;
  localparam int OUT_W       = 3 * BYTE_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'hF2;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic {
    CMD_WRITE,
    CMD_SCAN
  } cmd_kind_e;

  // For a write, addr is the store entry; for a scan, it is the first row of
  // the layer in the shown half.
  typedef struct packed {
    cmd_kind_e               kind;
    logic [STORE_AW-1:0]     addr;
    logic [BYTE_W-1:0]       data;
    logic [SIDE_W-1:0]       layer;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] one_hot8(input logic [SIDE_W-1:0] pos);
    one_hot8 = {{(BYTE_W-1){1'b0}}, 1'b1} << pos;
  endfunction

endpackage

>>> hdl/lcube_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcube_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lcube_front.sv
// ----------------------------------------------------------------------------
// LED cube front end
// Accepts input words, tracks the batch and the scan layer, and turns each
// refresh tick into a layer scan command and each batch byte into a store write.
// ----------------------------------------------------------------------------
module lcube_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lcube_pkg::BYTE_W-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lcube_pkg::BYTE_W-1:0] cfg_data_i,
  output logic                        push_o,
  output lcube_pkg::cmd_t             cmd_o,
  input  logic                        full_i
);
  import lcube_pkg::*;

  logic [BYTE_W-1:0]   marker_q;
  logic                batch_q, batch_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                shown_q, shown_d;
  logic [SIDE_W-1:0]   layer_q, layer_d;
  logic                accept;
  logic [STORE_AW-1:0] back_base;
  logic [STORE_AW-1:0] shown_base;

  assign s_axis_tready = !full_i;
  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign back_base  = shown_q ? '0 : STORE_AW'(FRAME_BYTES);
  assign shown_base = shown_q ? STORE_AW'(FRAME_BYTES) : '0;

  always_comb begin
    batch_d     = batch_q;
    count_d     = count_q;
    shown_d     = shown_q;
    layer_d     = layer_q;
    push_o      = 1'b0;
    cmd_o.kind  = CMD_SCAN;
    cmd_o.addr  = shown_base + STORE_AW'(layer_q) * STORE_AW'(CUBE_SIDE);
    cmd_o.data  = s_axis_tdata;
    cmd_o.layer = layer_q;
    if (accept) begin
      if (s_axis_tuser == REQ_TICK) begin
        push_o  = 1'b1;
        layer_d = (layer_q == SIDE_W'(CUBE_SIDE - 1)) ? '0 : layer_q + 1'b1;
      end else if (!batch_q) begin
        if (s_axis_tdata == marker_q) begin
          batch_d = 1'b1;
          count_d = '0;
        end
      end else begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_WRITE;
        cmd_o.addr = back_base + STORE_AW'(count_q);
        if (count_q == COUNT_W'(FRAME_BYTES - 1)) begin
          shown_d = !shown_q;
          batch_d = 1'b0;
          count_d = '0;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MARKER_RESET;
      batch_q  <= 1'b0;
      count_q  <= '0;
      shown_q  <= 1'b0;
      layer_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        marker_q <= cfg_data_i;
      end
      batch_q <= batch_d;
      count_q <= count_d;
      shown_q <= shown_d;
      layer_q <= layer_d;
    end
  end

endmodule

>>> hdl/lcube_cmd_fifo.sv
// ----------------------------------------------------------------------------
// LED cube command queue
// Short register queue between the front end and the scan engine.
// ----------------------------------------------------------------------------
module lcube_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcube_pkg::cmd_t cmd_i,
  output logic            full_o,
  output logic            valid_o,
  output lcube_pkg::cmd_t cmd_o,
  input  logic            pop_i
);
  import lcube_pkg::*;

  cmd_t                  entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q;
  logic [QUEUE_AW-1:0]   rd_ptr_q;
  logic [QUEUE_AW:0]     fill_q;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> hdl/lcube_back.sv
// ----------------------------------------------------------------------------
// LED cube scan engine
// Executes queued commands: writes frame bytes into the store, and scans one
// layer into row words followed by the layer drive word.
// ----------------------------------------------------------------------------
module lcube_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  lcube_pkg::cmd_t             cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lcube_pkg::OUT_W-1:0] out_data_o,
  output logic                        out_last_o
);
  import lcube_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWS,
    ST_DRIVE
  } state_e;

  state_e                 state_q;
  logic [STORE_AW-1:0]    base_q;
  logic [SIDE_W-1:0]      layer_q;
  logic [SIDE_W-1:0]      row_q;
  logic [STORE_BYTES-1:0] written_q;
  logic                   rd_written_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_data_q;
  logic                   out_last_q;

  logic                   out_free;
  logic                   row_last;
  logic                   ram_we;
  logic                   ram_re;
  logic [STORE_AW-1:0]    ram_raddr;
  logic [BYTE_W-1:0]      ram_rdata;
  logic [BYTE_W-1:0]      row_byte;

  assign out_free  = !out_valid_q || out_ready_i;
  assign row_last  = (row_q == SIDE_W'(CUBE_SIDE - 1));
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign ram_we    = cmd_pop_o && (cmd_i.kind == CMD_WRITE);
  assign row_byte  = rd_written_q ? ram_rdata : '0;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cmd_i.addr;
    if (cmd_pop_o && (cmd_i.kind == CMD_SCAN)) begin
      ram_re = 1'b1;
    end else if ((state_q == ST_ROWS) && out_free && !row_last) begin
      ram_re    = 1'b1;
      ram_raddr = base_q + STORE_AW'(row_q) + 1'b1;
    end
  end

  lcube_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_i.addr),
    .wdata_i(cmd_i.data),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      base_q       <= '0;
      layer_q      <= '0;
      row_q        <= '0;
      written_q    <= '0;
      rd_written_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (ram_we) begin
        written_q[cmd_i.addr] <= 1'b1;
      end
      if (ram_re) begin
        rd_written_q <= written_q[ram_raddr];
      end
      if (out_free) begin
        out_valid_q <= (state_q == ST_ROWS) || (state_q == ST_DRIVE);
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && (cmd_i.kind == CMD_SCAN)) begin
            base_q  <= cmd_i.addr;
            layer_q <= cmd_i.layer;
            row_q   <= '0;
            state_q <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          if (out_free) begin
            out_data_q  <= {{BYTE_W{1'b0}}, row_byte, one_hot8(row_q)};
            out_last_q  <= 1'b0;
            if (row_last) begin
              state_q <= ST_DRIVE;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end
        end
        ST_DRIVE: begin
          if (out_free) begin
            out_data_q  <= {one_hot8(layer_q), {BYTE_W{1'b0}}, {BYTE_W{1'b0}}};
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

>>> hdl/led_cube_frame_loader_and_scan.sv
// ----------------------------------------------------------------------------
// Double-buffered LED cube loader and scan driver
// Loads frames from serial bytes into a back buffer and scans the shown
// buffer one layer per refresh tick.
// ----------------------------------------------------------------------------
// Input words carry a received byte (tuser 0) or a refresh tick (tuser 1);
// after the start marker byte, the next 64 bytes fill the back buffer and the
// buffers then swap. A refresh tick gives nine output words: eight row words
// and a layer drive word marked with tlast. The scan engine pops a tick
// together with the first store read, then sends the row words and the
// drive word, and only then takes the next command. A data byte is written
// into the store as its command is popped, and bytes that only open a
// batch or are ignored send no command to it. Input words are accepted
// whenever the two-entry command queue has room, so up to two commands
// can wait while a scan is being sent. The start marker resets to 0xF2 and
// the store reads as zero until written; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module led_cube_frame_loader_and_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lcube_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic                          s_axis_tuser,  // [0] req_type
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcube_pkg::BYTE_W-1:0]  cfg_data_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] row_strobe, [15:8] row_data, [23:16] layer_drive
  output logic [lcube_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast   // last_of_scan
);
  import lcube_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  lcube_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .full_i       (full)
  );

  lcube_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .valid_o(head_valid),
    .cmd_o  (head_cmd),
    .pop_i  (pop)
  );

  lcube_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED cube loader and scan driver testbench
// Drives serial bytes and refresh ticks into the input stream and scores every
// scan word against a local model of the double-buffered cube store.
// The run covers several start markers, frames that are cut short, long output
// stalls, and stretches with no idle cycles on either side.
// ----------------------------------------------------------------------------
module tb;
  import lcube_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int LONG_HOLD      = 200;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] strobe;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] drive;
    logic              last;
  } scan_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [BYTE_W-1:0]  s_axis_tdata = '0;  // [7:0] rx_byte
  logic               s_axis_tuser = REQ_BYTE;  // [0] req_type
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [BYTE_W-1:0]  cfg_data_i = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;  // [7:0] row_strobe, [15:8] row_data, [23:16] layer_drive
  logic               m_axis_tlast;  // last_of_scan

  // Local image of the cube driver.
  logic [BYTE_W-1:0]  cube_img [STORE_BYTES];
  logic [BYTE_W-1:0]  marker_reg;
  logic               shown_half;
  logic               loading;
  int                 load_count;
  int                 layer_ptr;

  scan_word_t         scan_words_q [$];

  int  errors;
  int  useful_items;
  int  ticks_sent;
  int  frames_loaded;
  int  words_checked;
  int  marker_writes;
  int  hold_left;
  int  stall_left;
  int  idle_cycles;
  bit  no_gaps;

  led_cube_frame_loader_and_scan dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Returns 1 when the word changes state or produces scan words.
  function automatic bit cube_model_accept(input logic kind, input logic [BYTE_W-1:0] rx);
    scan_word_t w;
    int         base;
    if (kind == REQ_TICK) begin
      base = (shown_half ? FRAME_BYTES : 0) + layer_ptr * CUBE_SIDE;
      for (int row = 0; row < CUBE_SIDE; row++) begin
        w.strobe = (row < 8) ? (8'h01 << row) : 8'h00;
        w.data   = cube_img[base + row];
        w.drive  = 8'h00;
        w.last   = 1'b0;
        scan_words_q.push_back(w);
      end
      w.strobe = 8'h00;
      w.data   = 8'h00;
      w.drive  = (layer_ptr < 8) ? (8'h01 << layer_ptr) : 8'h00;
      w.last   = 1'b1;
      scan_words_q.push_back(w);
      layer_ptr = (layer_ptr + 1 < CUBE_SIDE) ? layer_ptr + 1 : 0;
      ticks_sent++;
      return 1'b1;
    end
    if (!loading) begin
      if (rx != marker_reg) return 1'b0;
      loading    = 1'b1;
      load_count = 0;
      return 1'b1;
    end
    cube_img[(shown_half ? 0 : FRAME_BYTES) + load_count] = rx;
    load_count++;
    if (load_count >= FRAME_BYTES) begin
      shown_half = ~shown_half;
      loading    = 1'b0;
      load_count = 0;
      frames_loaded++;
    end
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
  endfunction

  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] rx);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (cube_model_accept(kind, rx)) useful_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (scan_words_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [BYTE_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    marker_reg = value;
    marker_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_pixel_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return marker_reg;
    if (r < 12) return 8'h00;
    if (r < 18) return 8'hFF;
    return BYTE_W'($urandom);
  endfunction

  // A marker, then a full frame or, now and then, a frame cut short, with refresh ticks mixed in.
  task automatic send_frame();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    send_item(REQ_BYTE, marker_reg);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) send_item(REQ_TICK, BYTE_W'($urandom));
      send_item(REQ_BYTE, pick_pixel_byte());
    end
  endtask

  task automatic test_reset_scan();
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_TICK, 8'hFF);
    for (int i = 2; i <= CUBE_SIDE; i++) send_item(REQ_TICK, BYTE_W'($urandom));
  endtask

  task automatic test_idle_bytes();
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_BYTE, MARKER_RESET ^ 8'h01);
    send_item(REQ_BYTE, MARKER_RESET ^ 8'h80);
    send_item(REQ_BYTE, 8'h5A);
    send_item(REQ_TICK, 8'h00);
  endtask

  task automatic test_frame_loads(input int target);
    int goal;
    int sel;
    goal = useful_items + target;
    while (useful_items < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        send_frame();
      end else if (sel < 80) begin
        repeat ($urandom_range(1, 4)) send_item(REQ_TICK, BYTE_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(REQ_BYTE, BYTE_W'($urandom));
      end
    end
  endtask

  task automatic test_output_hold();
    wait_drained();
    hold_left = LONG_HOLD;
    repeat (12) send_item(REQ_TICK, BYTE_W'($urandom));
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (no_gaps) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : score_scan_word
    scan_word_t want;
    scan_word_t got;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast};
      words_checked++;
      if (scan_words_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word strobe=%h data=%h drive=%h last=%b",
                                got.strobe, got.data, got.drive, got.last));
      end else begin
        want = scan_words_q.pop_front();
        if (got !== want)
          note_mismatch($sformatf(
            "strobe %h/%h data %h/%h drive %h/%h last %b/%b (expected/actual)",
            want.strobe, got.strobe, want.data, got.data,
            want.drive, got.drive, want.last, got.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] Timeout: no handshake for %0d cycles, %0d words outstanding",
                 $realtime, idle_cycles, scan_words_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (cube_img[i]) cube_img[i] = '0;
    marker_reg = MARKER_RESET;
    shown_half = 1'b0;
    loading    = 1'b0;
    load_count = 0;
    layer_ptr  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_scan();
    test_idle_bytes();
    test_frame_loads(50);
    write_marker(8'h00);
    test_frame_loads(50);
    write_marker(8'hFF);
    no_gaps = 1'b1;
    test_frame_loads(50);
    no_gaps = 1'b0;
    write_marker(BYTE_W'($urandom));
    test_frame_loads(50);
    test_output_hold();

    wait_drained();
    errors += scan_words_q.size();
    $display("Sent %0d effective words (%0d refresh ticks), loaded %0d frames,",
             useful_items, ticks_sent, frames_loaded);
    $display("checked %0d scan words; start marker set %0d times including 0x00 and 0xFF.",
             words_checked, marker_writes);
    $display("Output was held off for %0d cycles once while input kept coming.", LONG_HOLD);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lcube_pkg.sv
hdl/lcube_ram.sv
hdl/lcube_front.sv
hdl/lcube_cmd_fifo.sv
hdl/lcube_back.sv
hdl/led_cube_frame_loader_and_scan.sv
tb/sv/tb.sv
